[src/pmwq_pkg.sv]
package pmwq_pkg;

    localparam int LEVELS_DEF = 32;
    localparam int TASKS_DEF  = 64;

    localparam int KIND_W   = 2;
    localparam int TASK_W   = 6;
    localparam int LEVEL_W  = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;
    localparam int ID_SPACE = 2 ** TASK_W;

    localparam logic [KIND_W-1:0] KIND_TRY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEVEL,
        S_LINK,
        S_DONE
    } state_t;

endpackage

[src/priority_mutex_wait_queue.sv]
// priority_mutex_wait_queue: hardware mutex with priority-ordered FIFO waiters.
// Request channel (req_valid / req_stall) carries one word per request: kind
// (try-lock, lock, unlock), requester_task and req_level. Response channel
// (rsp_valid / rsp_stall) returns exactly one word per request, in order:
// status, woken_valid, woken_task, woken_level and waiting_total.
// Waiters live in a per-level memory (count, head, tail) and a per-task link
// memory, both with registered read data. A request is accepted while the
// level entry is read; the block then decides and writes back. An unlock that
// pops a level holding two or more waiters also reads the link entry of the
// old head after the level entry, then writes the level entry back.
// One request is in flight at a time, so a new request is not taken until the
// previous one has been handed to the output register.
// The response sits in an output register; a new request is taken while it
// waits. When rsp_stall holds the register full, the next finished request
// waits in the block and req_stall stays high until the word can move.
// Reset frees the mutex and empties all queues at once; an occupancy bitmap
// marks which level entries are live, so no clearing pass is needed.
module priority_mutex_wait_queue
    import pmwq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int TASKS  = TASKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [TASK_W-1:0]   requester_task,
    input  logic [LEVEL_W-1:0]  req_level,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic                woken_valid,
    output logic [TASK_W-1:0]   woken_task,
    output logic [LEVEL_W-1:0]  woken_level,
    output logic [TOTAL_W-1:0]  waiting_total
);

    localparam int LW   = $clog2(LEVELS);
    localparam int TW   = $clog2(TASKS);
    localparam int CW   = $clog2(TASKS + 1);
    localparam int EW   = CW + 2 * TW;
    localparam int LVW1 = LEVEL_W + 1;

    state_t state_reg, state_next;

    logic                holder_valid_reg, holder_valid_next;
    logic [TW-1:0]       holder_task_reg, holder_task_next;
    logic [LEVELS-1:0]   bitmap_reg, bitmap_next;
    logic [CW-1:0]       waiting_count_reg, waiting_count_next;

    logic [KIND_W-1:0]   cur_kind_reg, cur_kind_next;
    logic [TW-1:0]       cur_task_reg, cur_task_next;
    logic [LW-1:0]       lvl_addr_reg, lvl_addr_next;

    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_wv_reg, pend_wv_next;
    logic [TW-1:0]       pend_wt_reg, pend_wt_next;
    logic [LW-1:0]       pend_wl_reg, pend_wl_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                woken_valid_reg, woken_valid_next;
    logic [TASK_W-1:0]   woken_task_reg, woken_task_next;
    logic [LEVEL_W-1:0]  woken_level_reg, woken_level_next;
    logic [TOTAL_W-1:0]  waiting_total_reg, waiting_total_next;

    logic [EW-1:0]       lvl_mem [LEVELS];
    logic [EW-1:0]       lvl_rdata_reg;
    logic                lvl_rd_en;
    logic [LW-1:0]       lvl_raddr;
    logic                lvl_we;
    logic [EW-1:0]       lvl_wdata;

    logic [TW-1:0]       link_mem [TASKS];
    logic [TW-1:0]       link_rdata_reg;
    logic                link_rd_en;
    logic [TW-1:0]       link_raddr;
    logic                link_we;
    logic [TW-1:0]       link_waddr;
    logic [TW-1:0]       link_wdata;

    logic [TW-1:0]       task_mod [ID_SPACE];
    logic [LW-1:0]       req_lv;
    logic [LW-1:0]       top_lv;

    logic [CW-1:0]       rd_cnt;
    logic [TW-1:0]       rd_head;
    logic [TW-1:0]       rd_tail;
    logic [CW-1:0]       cnt;
    logic                rsp_free;

    logic                emit;
    logic [STATUS_W-1:0] em_status;
    logic                em_wv;
    logic [TW-1:0]       em_wt;
    logic [LW-1:0]       em_wl;
    logic [CW-1:0]       em_total;

    logic [STATUS_W-1:0] dec_status;
    logic                dec_wv;
    logic [TW-1:0]       dec_wt;
    logic                need_link;

    // task id folded into the task range
    for (genvar g = 0; g < ID_SPACE; g++)
    begin : g_mod
        assign task_mod[g] = TW'(g % TASKS);
    end

    always_comb
    begin
        if ({1'b0, req_level} >= LVW1'(LEVELS))
            req_lv = LW'(LEVELS - 1);
        else
            req_lv = LW'(req_level);
    end

    // highest occupied level
    always_comb
    begin
        top_lv = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (bitmap_reg[i])
                top_lv = LW'(i);
        end
    end

    assign rd_cnt  = lvl_rdata_reg[EW-1 -: CW];
    assign rd_head = lvl_rdata_reg[2*TW-1 -: TW];
    assign rd_tail = lvl_rdata_reg[TW-1:0];
    assign cnt     = bitmap_reg[lvl_addr_reg] ? rd_cnt : '0;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (lvl_rd_en)
            lvl_rdata_reg <= lvl_mem[lvl_raddr];
        if (lvl_we)
            lvl_mem[lvl_addr_reg] <= lvl_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (link_rd_en)
            link_rdata_reg <= link_mem[link_raddr];
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            holder_valid_reg  <= 1'b0;
            holder_task_reg   <= '0;
            bitmap_reg        <= '0;
            waiting_count_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            holder_valid_reg  <= holder_valid_next;
            holder_task_reg   <= holder_task_next;
            bitmap_reg        <= bitmap_next;
            waiting_count_reg <= waiting_count_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_kind_reg      <= cur_kind_next;
        cur_task_reg      <= cur_task_next;
        lvl_addr_reg      <= lvl_addr_next;
        pend_status_reg   <= pend_status_next;
        pend_wv_reg       <= pend_wv_next;
        pend_wt_reg       <= pend_wt_next;
        pend_wl_reg       <= pend_wl_next;
        status_reg        <= status_next;
        woken_valid_reg   <= woken_valid_next;
        woken_task_reg    <= woken_task_next;
        woken_level_reg   <= woken_level_next;
        waiting_total_reg <= waiting_total_next;
    end

    // decision on the level entry just read, and level write-back after a link read
    always_comb
    begin
        dec_status         = ST_NOT_OWNER;
        dec_wv             = 1'b0;
        dec_wt             = '0;
        need_link          = 1'b0;
        holder_valid_next  = holder_valid_reg;
        holder_task_next   = holder_task_reg;
        bitmap_next        = bitmap_reg;
        waiting_count_next = waiting_count_reg;
        lvl_we             = 1'b0;
        lvl_wdata          = lvl_rdata_reg;
        link_we            = 1'b0;
        link_waddr         = rd_tail;
        link_wdata         = cur_task_reg;
        link_rd_en         = 1'b0;
        link_raddr         = rd_head;

        if (state_reg == S_LEVEL)
        begin
            unique case (cur_kind_reg)
                KIND_TRY:
                begin
                    if (!holder_valid_reg)
                    begin
                        holder_valid_next = 1'b1;
                        holder_task_next  = cur_task_reg;
                        dec_status        = ST_ACQUIRED;
                    end
                    else
                        dec_status = ST_BUSY;
                end
                KIND_LOCK:
                begin
                    if (!holder_valid_reg)
                    begin
                        holder_valid_next = 1'b1;
                        holder_task_next  = cur_task_reg;
                        dec_status        = ST_ACQUIRED;
                    end
                    else if (holder_task_reg == cur_task_reg)
                        dec_status = ST_ALREADY;
                    else if (waiting_count_reg >= CW'(TASKS))
                        dec_status = ST_BUSY;
                    else
                    begin
                        dec_status = ST_QUEUED;
                        lvl_we     = 1'b1;
                        lvl_wdata  = {cnt + CW'(1),
                                      (cnt == '0) ? cur_task_reg : rd_head,
                                      cur_task_reg};
                        link_we    = (cnt != '0);
                        waiting_count_next = waiting_count_reg + CW'(1);
                        bitmap_next[lvl_addr_reg] = 1'b1;
                    end
                end
                KIND_UNLOCK:
                begin
                    if (holder_valid_reg && holder_task_reg == cur_task_reg)
                    begin
                        holder_valid_next = 1'b0;
                        holder_task_next  = '0;
                        dec_status        = ST_RELEASED;
                        if (bitmap_reg[lvl_addr_reg])
                        begin
                            dec_wv = 1'b1;
                            dec_wt = rd_head;
                            waiting_count_next = waiting_count_reg - CW'(1);
                            if (rd_cnt == CW'(1))
                                bitmap_next[lvl_addr_reg] = 1'b0;
                            else
                            begin
                                need_link  = 1'b1;
                                link_rd_en = 1'b1;
                            end
                        end
                    end
                end
                default:
                    dec_status = ST_NOT_OWNER;
            endcase
        end
        else if (state_reg == S_LINK)
        begin
            lvl_we    = 1'b1;
            lvl_wdata = {rd_cnt - CW'(1), link_rdata_reg, rd_tail};
        end
    end

    // sequencing and response register
    always_comb
    begin
        state_next       = state_reg;
        cur_kind_next    = cur_kind_reg;
        cur_task_next    = cur_task_reg;
        lvl_addr_next    = lvl_addr_reg;
        lvl_rd_en        = 1'b0;
        lvl_raddr        = req_lv;
        pend_status_next = pend_status_reg;
        pend_wv_next     = pend_wv_reg;
        pend_wt_next     = pend_wt_reg;
        pend_wl_next     = pend_wl_reg;
        emit             = 1'b0;
        em_status        = pend_status_reg;
        em_wv            = pend_wv_reg;
        em_wt            = pend_wt_reg;
        em_wl            = pend_wl_reg;
        em_total         = waiting_count_reg;
        req_stall        = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_kind_next = kind;
                    cur_task_next = task_mod[requester_task];
                    if (kind == KIND_UNLOCK)
                        lvl_raddr = top_lv;
                    lvl_addr_next = lvl_raddr;
                    lvl_rd_en     = 1'b1;
                    state_next    = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                pend_status_next = dec_status;
                pend_wv_next     = dec_wv;
                pend_wt_next     = dec_wt;
                pend_wl_next     = dec_wv ? lvl_addr_reg : '0;
                if (need_link)
                    state_next = S_LINK;
                else if (rsp_free)
                begin
                    emit       = 1'b1;
                    em_status  = dec_status;
                    em_wv      = dec_wv;
                    em_wt      = dec_wt;
                    em_wl      = dec_wv ? lvl_addr_reg : '0;
                    em_total   = waiting_count_next;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DONE;
            end
            S_LINK:
            begin
                if (rsp_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        status_next        = status_reg;
        woken_valid_next   = woken_valid_reg;
        woken_task_next    = woken_task_reg;
        woken_level_next   = woken_level_reg;
        waiting_total_next = waiting_total_reg;
        if (emit)
        begin
            rsp_valid_next     = 1'b1;
            status_next        = em_status;
            woken_valid_next   = em_wv;
            woken_task_next    = TASK_W'(em_wt);
            woken_level_next   = LEVEL_W'(em_wl);
            waiting_total_next = TOTAL_W'(em_total);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign woken_valid   = woken_valid_reg;
    assign woken_task    = woken_task_reg;
    assign woken_level   = woken_level_reg;
    assign waiting_total = waiting_total_reg;

endmodule

[bench/tb_priority_mutex_wait_queue.sv]
module tb_priority_mutex_wait_queue;
    import pmwq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [TASK_W-1:0]   woken_task;
        logic [LEVEL_W-1:0]  woken_level;
        logic [TOTAL_W-1:0]  waiting_total;
    } mutex_reply_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [KIND_W-1:0]   kind = KIND_TRY;
    logic [TASK_W-1:0]   requester_task = '0;
    logic [LEVEL_W-1:0]  req_level = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [TASK_W-1:0]   woken_task;
    logic [LEVEL_W-1:0]  woken_level;
    logic [TOTAL_W-1:0]  waiting_total;

    // mutex and wait list mirror
    bit                  m_held = 1'b0;
    logic [TASK_W-1:0]   m_owner = '0;
    logic [31:0]         m_busy_levels = '0;
    int                  m_level_len [LEVELS_DEF] = '{default: 0};
    logic [TASK_W-1:0]   m_first [LEVELS_DEF] = '{default: '0};
    logic [TASK_W-1:0]   m_last [LEVELS_DEF] = '{default: '0};
    logic [TASK_W-1:0]   m_link [TASKS_DEF] = '{default: '0};
    int                  m_queued_as [TASKS_DEF] = '{default: 0};
    int                  m_waiting = 0;
    logic [TASK_W-1:0]   m_last_woken = '0;

    mutex_reply_t        awaited_replies [$];
    int                  mismatches = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         reply_stall_pct = 0;
    int                  hold_len = 0;

    priority_mutex_wait_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .requester_task (requester_task),
        .req_level      (req_level),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .woken_valid    (woken_valid),
        .woken_task     (woken_task),
        .woken_level    (woken_level),
        .waiting_total  (waiting_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mutex_reply_t grant_outcome(input logic [KIND_W-1:0] k,
                                                   input logic [TASK_W-1:0] t,
                                                   input logic [LEVEL_W-1:0] l);
        mutex_reply_t r;
        int top;
        logic [TASK_W-1:0] h;
        r = '0;
        r.status = ST_NOT_OWNER;
        if (k == KIND_TRY)
        begin
            if (!m_held)
            begin
                m_held = 1'b1;
                m_owner = t;
                r.status = ST_ACQUIRED;
            end
            else
                r.status = ST_BUSY;
        end
        else if (k == KIND_LOCK)
        begin
            if (!m_held)
            begin
                m_held = 1'b1;
                m_owner = t;
                r.status = ST_ACQUIRED;
            end
            else if (m_owner == t)
                r.status = ST_ALREADY;
            else if (m_waiting >= TASKS_DEF)
                r.status = ST_BUSY;
            else
            begin
                if (m_level_len[l] == 0)
                    m_first[l] = t;
                else
                    m_link[m_last[l]] = t;
                m_last[l] = t;
                m_level_len[l]++;
                m_waiting++;
                m_queued_as[t]++;
                m_busy_levels[l] = 1'b1;
                r.status = ST_QUEUED;
            end
        end
        else if (k == KIND_UNLOCK)
        begin
            if (m_held && m_owner == t)
            begin
                m_held = 1'b0;
                m_owner = '0;
                r.status = ST_RELEASED;
                if (m_busy_levels != 0)
                begin
                    top = 31;
                    while (top > 0 && !m_busy_levels[top])
                        top--;
                    h = m_first[top];
                    r.woken_valid = 1'b1;
                    r.woken_task = h;
                    r.woken_level = LEVEL_W'(top);
                    m_last_woken = h;
                    if (m_queued_as[h] > 0)
                        m_queued_as[h]--;
                    if (m_level_len[top] > 1)
                        m_first[top] = m_link[h];
                    m_level_len[top]--;
                    m_waiting--;
                    if (m_level_len[top] == 0)
                        m_busy_levels[top] = 1'b0;
                end
            end
        end
        r.waiting_total = TOTAL_W'(m_waiting);
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] k, input logic [TASK_W-1:0] t,
                                input logic [LEVEL_W-1:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        requester_task <= t;
        req_level <= l;
        do
            @(posedge clk);
        while (req_stall);
        awaited_replies.push_back(grant_outcome(k, t, l));
    endtask

    task automatic wait_for_replies();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
    endtask

    // hand the mutex around until nobody holds or waits for it
    task automatic release_everyone();
        while (m_held || m_waiting != 0)
        begin
            if (m_held)
                send_request(KIND_UNLOCK, m_owner, LEVEL_W'($urandom_range(31)));
            else
                send_request(KIND_LOCK, m_last_woken, LEVEL_W'($urandom_range(31)));
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        reply_stall_pct = 0;
        send_request(KIND_UNLOCK, 6'd5, 5'd3);
        send_request(KIND_SPARE, 6'd63, 5'd31);
        send_request(KIND_TRY, 6'd0, 5'd0);
        send_request(KIND_TRY, 6'd0, 5'd0);
        send_request(KIND_TRY, 6'd63, 5'd31);
        send_request(KIND_LOCK, 6'd0, 5'd9);
        send_request(KIND_LOCK, 6'd63, 5'd31);
        send_request(KIND_LOCK, 6'd1, 5'd0);
        send_request(KIND_LOCK, 6'd2, 5'd31);
        send_request(KIND_LOCK, 6'd3, 5'd17);
        send_request(KIND_LOCK, 6'd4, 5'd0);
        send_request(KIND_UNLOCK, 6'd63, 5'd31);
        send_request(KIND_SPARE, 6'd0, 5'd0);
        send_request(KIND_UNLOCK, 6'd0, 5'd0);
        send_request(KIND_UNLOCK, 6'd0, 5'd0);
        send_request(KIND_LOCK, 6'd63, 5'd31);
        send_request(KIND_LOCK, 6'd63, 5'd31);
        send_request(KIND_LOCK, 6'd5, 5'd17);
        send_request(KIND_LOCK, 6'd5, 5'd17);
        send_request(KIND_UNLOCK, 6'd63, 5'd31);
        send_request(KIND_LOCK, 6'd2, 5'd31);
        send_request(KIND_UNLOCK, 6'd2, 5'd31);
        send_request(KIND_TRY, 6'd42, 5'd21);
        send_request(KIND_UNLOCK, 6'd42, 5'd10);
        release_everyone();
        wait_for_replies();
    endtask

    task automatic test_queue_full();
        logic [LEVEL_W-1:0] l;
        send_idle_pct = 32;
        reply_stall_pct = 32;
        send_request(KIND_TRY, 6'd0, 5'd0);
        for (int i = 1; i < TASKS_DEF; i++)
        begin
            l = LEVEL_W'($urandom_range(31));
            if (i == 1)
                l = 5'd0;
            else if (i == 2)
                l = 5'd31;
            send_request(KIND_LOCK, TASK_W'(i), l);
        end
        // duplicate entry takes the last free slot
        send_request(KIND_LOCK, 6'd1, 5'd31);
        send_request(KIND_LOCK, 6'd40, 5'd12);
        send_request(KIND_LOCK, 6'd0, 5'd3);
        send_request(KIND_TRY, 6'd9, 5'd9);
        release_everyone();
        wait_for_replies();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        reply_stall_pct = 0;
        hold_len = 300;
        for (int i = 0; i < 12; i++)
            send_request(i[0] ? KIND_LOCK : KIND_TRY, TASK_W'($urandom_range(63)),
                         LEVEL_W'($urandom_range(31)));
        // sender waits for every reply before going on
        wait_for_replies();
        release_everyone();
        wait_for_replies();
    endtask

    task automatic test_random_traffic();
        int unsigned r;
        logic [KIND_W-1:0] k;
        logic [TASK_W-1:0] t;
        logic [LEVEL_W-1:0] l;
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    reply_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 76;
                    reply_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    reply_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 32;
                    reply_stall_pct = 32;
                end
            endcase
            for (int i = 0; i < 210; i++)
            begin
                r = $urandom_range(99);
                t = TASK_W'($urandom_range(63));
                if ($urandom_range(9) == 0)
                    l = $urandom_range(1) ? 5'd31 : 5'd0;
                else
                    l = LEVEL_W'($urandom_range(31));
                if (r < 30)
                begin
                    k = KIND_LOCK;
                    if (m_queued_as[t] != 0 && $urandom_range(9) != 0)
                        t = TASK_W'($urandom_range(63));
                end
                else if (r < 42)
                    k = KIND_TRY;
                else if (r < 72)
                begin
                    k = KIND_UNLOCK;
                    if (m_held)
                        t = m_owner;
                end
                else if (r < 82)
                    k = KIND_UNLOCK;
                else if (r < 88)
                    k = KIND_SPARE;
                else if (r < 94)
                begin
                    k = KIND_LOCK;
                    if (m_held)
                        t = m_owner;
                end
                else
                begin
                    k = KIND_LOCK;
                    t = m_last_woken;
                end
                send_request(k, t, l);
            end
            wait_for_replies();
        end
    endtask

    // reply side pacing, with an occasional long hold
    initial
    begin : reply_pacer
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                n = hold_len;
                hold_len = 0;
                repeat (n)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= ($urandom_range(99) < reply_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        mutex_reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 8'(want.status), 8'(status));
                check_field("woken_valid", 8'(want.woken_valid), 8'(woken_valid));
                check_field("woken_task", 8'(want.woken_task), 8'(woken_task));
                check_field("woken_level", 8'(want.woken_level), 8'(woken_level));
                check_field("waiting_total", 8'(want.waiting_total), 8'(waiting_total));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_queue_full();
        test_output_hold();
        test_random_traffic();
        wait_for_replies();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
